/* rtl/lngm_pkg.sv */
// ----------------------------------------------------------------------------
// lngm_pkg: shared types and constants of the note gate matcher
// Slot count, request codes, cell operation codes and the beat structs.
// ----------------------------------------------------------------------------
package lngm_pkg;

  // Number of slots, one cell each
  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths of the beats
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned LSLT_W = 2;

  // Request codes; the fourth code is unused and changes nothing
  typedef enum logic [REQ_W-1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_LEARN    = 2'd2
  } req_type_e;

  // Operation carried down the cell chain
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_STORE = 2'd3
  } cell_op_e;

  // Input beat
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAN_W-1:0] midi_channel;
    logic [NOTE_W-1:0] note_number;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [MASK_W-1:0] gate_mask;
    logic              learning;
    logic [LSLT_W-1:0] learn_slot;
  } res_t;

  // Event handed from cell to cell
  typedef struct packed {
    logic                  vld;
    cell_op_e              op;
    logic [SLOT_IDX_W-1:0] slot;
    logic [CHAN_W-1:0]     chan;
    logic [NOTE_W-1:0]     note;
  } ev_t;

endpackage

/* rtl/lngm_cell.sv */
// ----------------------------------------------------------------------------
// lngm_cell: one slot of the note gate matcher
// Holds a slot's channel, note, valid and gate bits; applies the event that
// arrives from the previous cell and hands it on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module lngm_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lngm_pkg::SLOT_IDX_W-1:0] slot_idx_i,
  input  lngm_pkg::ev_t                   ev_i,
  output lngm_pkg::ev_t                   ev_o,
  output logic                            gate_o
);

  logic                        valid_q, valid_d;
  logic                        gate_q, gate_d;
  logic [lngm_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic [lngm_pkg::NOTE_W-1:0] note_q, note_d;
  logic                        ev_vld_q;
  lngm_pkg::ev_t               ev_q;
  logic                        match;

  // Slot hit: only learned slots can match
  assign match = valid_q && (chan_q == ev_i.chan) && (note_q == ev_i.note);

  // Slot update
  always_comb begin
    valid_d = valid_q;
    gate_d  = gate_q;
    chan_d  = chan_q;
    note_d  = note_q;
    if (ev_i.vld) begin
      unique case (ev_i.op)
        lngm_pkg::OP_OPEN: begin
          if (match) gate_d = 1'b1;
        end
        lngm_pkg::OP_CLOSE: begin
          if (match) gate_d = 1'b0;
        end
        lngm_pkg::OP_STORE: begin
          if (ev_i.slot == slot_idx_i) begin
            valid_d = 1'b1;
            chan_d  = ev_i.chan;
            note_d  = ev_i.note;
          end
        end
        default: ;
      endcase
    end
  end

  // Control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      gate_q   <= 1'b0;
      ev_vld_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      gate_q   <= gate_d;
      ev_vld_q <= ev_i.vld;
    end
  end

  // Slot payload and event hand-off, no reset
  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
    note_q <= note_d;
    ev_q   <= ev_i;
  end

  always_comb begin
    ev_o     = ev_q;
    ev_o.vld = ev_vld_q;
  end

  assign gate_o = gate_q;

endmodule

/* rtl/learnable_note_gate_matcher.sv */
// ----------------------------------------------------------------------------
// learnable_note_gate_matcher: MIDI note to gate slot matcher with learn mode
// Result strobe: done_o follows an accepted start through the launch register and the slot cells.
// One event at a time: the event walks the
// chain of slot cells one cell per cycle and busy stays high until done_o.
// Reset: all slots unlearned, gates closed, learn mode off, pointer at 0.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module learnable_note_gate_matcher (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lngm_pkg::req_t  req_i,
  output logic            done_o,
  output lngm_pkg::res_t  res_o
);

  localparam logic [lngm_pkg::SLOT_IDX_W-1:0] LastSlot =
    lngm_pkg::SLOT_IDX_W'(lngm_pkg::SLOT_COUNT - 1);

  logic                            busy_q, busy_d;
  logic                            learn_q, learn_d;
  logic [lngm_pkg::SLOT_IDX_W-1:0] ptr_q, ptr_d;
  logic                            launch_vld_q;
  lngm_pkg::ev_t                   launch_q, launch_d;
  lngm_pkg::ev_t                   chain [lngm_pkg::SLOT_COUNT+1];
  logic [lngm_pkg::SLOT_COUNT-1:0] gates;
  logic [lngm_pkg::SLOT_COUNT:0]   chain_vld;
  logic                            accept;

  assign accept = start && !busy_q;

  // Learn control and event launch
  always_comb begin
    learn_d       = learn_q;
    ptr_d         = ptr_q;
    launch_d.vld  = accept;
    launch_d.op   = lngm_pkg::OP_NONE;
    launch_d.slot = ptr_q;
    launch_d.chan = req_i.midi_channel;
    launch_d.note = req_i.note_number;
    if (accept) begin
      case (req_i.req_type)
        lngm_pkg::REQ_NOTE_ON: begin
          if (learn_q) begin
            launch_d.op = lngm_pkg::OP_STORE;
            if (ptr_q == LastSlot) begin
              learn_d = 1'b0;
              ptr_d   = '0;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end else begin
            launch_d.op = lngm_pkg::OP_OPEN;
          end
        end
        lngm_pkg::REQ_NOTE_OFF: begin
          if (!learn_q) launch_d.op = lngm_pkg::OP_CLOSE;
        end
        lngm_pkg::REQ_LEARN: begin
          learn_d = !learn_q;
          ptr_d   = '0;
        end
        default: ;
      endcase
    end
  end

  // Busy from accept until the result beat leaves the chain
  always_comb begin
    busy_d = busy_q;
    if (accept) busy_d = 1'b1;
    else if (chain[lngm_pkg::SLOT_COUNT].vld) busy_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      learn_q      <= 1'b0;
      ptr_q        <= '0;
      launch_vld_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      learn_q      <= learn_d;
      ptr_q        <= ptr_d;
      launch_vld_q <= launch_d.vld;
    end
  end

  // Launch payload
  always_ff @(posedge clk_i) begin
    launch_q <= launch_d;
  end

  always_comb begin
    chain[0]     = launch_q;
    chain[0].vld = launch_vld_q;
  end

  // Row of slot cells
  for (genvar i = 0; i < lngm_pkg::SLOT_COUNT; i++) begin : g_cell
    lngm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (lngm_pkg::SLOT_IDX_W'(i)),
      .ev_i       (chain[i]),
      .ev_o       (chain[i+1]),
      .gate_o     (gates[i])
    );
  end

  // Result beat
  assign done_o           = chain[lngm_pkg::SLOT_COUNT].vld;
  assign res_o.gate_mask  = lngm_pkg::MASK_W'(gates);
  assign res_o.learning   = learn_q;
  assign res_o.learn_slot = learn_q ? lngm_pkg::LSLT_W'(ptr_q) : '0;
  assign busy             = busy_q;

  always_comb begin
    for (int i = 0; i <= lngm_pkg::SLOT_COUNT; i++) begin
      chain_vld[i] = chain[i].vld;
    end
  end

  // At most one event in flight along the chain
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one event in the cell chain");

  // A result is only produced while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // Busy drops right after the result beat
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result");

  // An accepted event reaches the end of the chain on time
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##(lngm_pkg::SLOT_COUNT) done_o)
    else $error("result strobe missing");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the learnable note gate matcher
// Drives note-on, note-off, learn-toggle and unused-code events through the
// start/busy handshake and checks every result beat against a cycle-free
// model of the slot table, gate bits and learn pointer kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused request code, the one the package enum leaves out
  localparam logic [lngm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Cycles to wait once nothing is expected any more
  localparam int SETTLE_CYCLES = 2 * (lngm_pkg::SLOT_COUNT + 2);
  // Cycles without any beat before the run is declared hung
  localparam int STALL_LIMIT = 500;
  // Size of the note pool used to make learned notes come back
  localparam int POOL_SIZE = 6;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  lngm_pkg::req_t req_i  = '0;
  logic           done_o;
  lngm_pkg::res_t res_o;

  learnable_note_gate_matcher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #2 clk_i = ~clk_i;

  // Bench copy of the slot table and learn state
  logic                        slot_vld  [lngm_pkg::SLOT_COUNT] = '{default: 1'b0};
  logic [lngm_pkg::CHAN_W-1:0] slot_chan [lngm_pkg::SLOT_COUNT] = '{default: '0};
  logic [lngm_pkg::NOTE_W-1:0] slot_note [lngm_pkg::SLOT_COUNT] = '{default: '0};
  logic                        gate_bit  [lngm_pkg::SLOT_COUNT] = '{default: 1'b0};
  logic                        learn_on  = 1'b0;
  int unsigned                 learn_ptr = 0;

  // Status beats still to come, oldest first
  lngm_pkg::res_t expected_status_q [$];

  int   errors          = 0;
  int   events_sent     = 0;
  int   results_checked = 0;
  int   events_by_code [4] = '{default: 0};
  bit   idle_on         = 1'b0;
  int   quiet_cycles    = 0;

  logic [lngm_pkg::CHAN_W-1:0] pool_ch [POOL_SIZE];
  logic [lngm_pkg::NOTE_W-1:0] pool_nt [POOL_SIZE];

  // Apply one event to the bench state and return the status it reports
  function automatic lngm_pkg::res_t predict_status(lngm_pkg::req_t ev);
    lngm_pkg::res_t st;
    st = '0;
    case (ev.req_type)
      lngm_pkg::REQ_NOTE_ON: begin
        if (learn_on) begin
          if (learn_ptr < lngm_pkg::SLOT_COUNT) begin
            slot_chan[learn_ptr] = ev.midi_channel;
            slot_note[learn_ptr] = ev.note_number;
            slot_vld[learn_ptr]  = 1'b1;
          end
          learn_ptr = learn_ptr + 1;
          if (learn_ptr >= lngm_pkg::SLOT_COUNT) begin
            learn_on  = 1'b0;
            learn_ptr = 0;
          end
        end else begin
          for (int i = 0; i < lngm_pkg::SLOT_COUNT; i++)
            if (slot_vld[i] && slot_chan[i] == ev.midi_channel &&
                slot_note[i] == ev.note_number)
              gate_bit[i] = 1'b1;
        end
      end
      lngm_pkg::REQ_NOTE_OFF: begin
        // ignored while learning
        if (!learn_on)
          for (int i = 0; i < lngm_pkg::SLOT_COUNT; i++)
            if (slot_vld[i] && slot_chan[i] == ev.midi_channel &&
                slot_note[i] == ev.note_number)
              gate_bit[i] = 1'b0;
      end
      lngm_pkg::REQ_LEARN: begin
        learn_on  = !learn_on;
        learn_ptr = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < lngm_pkg::SLOT_COUNT && i < lngm_pkg::MASK_W; i++)
      st.gate_mask[i] = gate_bit[i];
    st.learning   = learn_on;
    st.learn_slot = learn_on ? lngm_pkg::LSLT_W'(learn_ptr) : '0;
    return st;
  endfunction

  function automatic lngm_pkg::req_t mk_event(logic [lngm_pkg::REQ_W-1:0]  code,
                                              logic [lngm_pkg::CHAN_W-1:0] ch,
                                              logic [lngm_pkg::NOTE_W-1:0] nt);
    lngm_pkg::req_t ev;
    ev.req_type     = code;
    ev.midi_channel = ch;
    ev.note_number  = nt;
    return ev;
  endfunction

  // Send one event beat; start stays high unless an idle burst follows
  task automatic send_event(lngm_pkg::req_t ev);
    int gap;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= ev;
    do @(posedge clk_i); while (busy);
    expected_status_q.push_back(predict_status(ev));
    events_sent++;
    events_by_code[ev.req_type]++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Hold the sender off until every pending status has come back
  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Pool note most of the time, any note otherwise
  task automatic pick_note(output logic [lngm_pkg::CHAN_W-1:0] ch,
                           output logic [lngm_pkg::NOTE_W-1:0] nt);
    int idx;
    if ($urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, POOL_SIZE - 1);
      ch  = pool_ch[idx];
      nt  = pool_nt[idx];
    end else begin
      ch = lngm_pkg::CHAN_W'($urandom_range(0, (1 << lngm_pkg::CHAN_W) - 1));
      nt = lngm_pkg::NOTE_W'($urandom_range(0, (1 << lngm_pkg::NOTE_W) - 1));
    end
  endtask

  // Note of a learned slot if one is picked, else a pool or random note
  task automatic pick_slot_note(output logic [lngm_pkg::CHAN_W-1:0] ch,
                                output logic [lngm_pkg::NOTE_W-1:0] nt);
    int idx;
    idx = $urandom_range(0, lngm_pkg::SLOT_COUNT - 1);
    if (slot_vld[idx]) begin
      ch = slot_chan[idx];
      nt = slot_note[idx];
    end else begin
      pick_note(ch, nt);
    end
  endtask

  // Nothing learned yet: unused code, note-off and note-on all leave zeros
  task automatic test_reset_state();
    send_event(mk_event(REQ_UNUSED, 4'd15, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd15, 7'd127));
  endtask

  // Fill every slot with field extremes; note-off and unused code in between
  task automatic test_learn_fill();
    send_event(mk_event(lngm_pkg::REQ_LEARN, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, 4'd3, 7'd60));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd15, 7'd127));
    send_event(mk_event(REQ_UNUSED, 4'd7, 7'd33));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd15, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd127));
  endtask

  // Open each gate, miss once, then close two of them
  task automatic test_gate_match();
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd15, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd15, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd9, 7'd64));
    send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, 4'd15, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, 4'd0, 7'd0));
  endtask

  // Relearn over open gates, stop early, then hit two slots with one note
  task automatic test_relearn();
    send_event(mk_event(lngm_pkg::REQ_LEARN, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd5, 7'd42));
    send_event(mk_event(lngm_pkg::REQ_LEARN, 4'd15, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_ON, 4'd0, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, 4'd0, 7'd127));
    send_event(mk_event(lngm_pkg::REQ_LEARN, 4'd0, 7'd0));
    send_event(mk_event(lngm_pkg::REQ_LEARN, 4'd0, 7'd0));
  endtask

  // Mostly learn sequences and note traffic on learned notes, plus noise
  task automatic test_random_traffic(int target);
    int                          sent0;
    int                          done_cnt;
    int                          blk;
    int                          r;
    int                          k;
    logic [lngm_pkg::CHAN_W-1:0] ch;
    logic [lngm_pkg::NOTE_W-1:0] nt;
    sent0 = events_sent;
    blk   = 0;
    done_cnt = 0;
    while (done_cnt < target) begin
      // every hundred beats: new idle mode, a new pool every other time, sometimes a full drain
      if (done_cnt >= blk * 100) begin
        blk++;
        idle_on = ($urandom_range(0, 3) != 0);
        if (blk % 2 == 1)
          for (int i = 0; i < POOL_SIZE; i++) begin
            pool_ch[i] = lngm_pkg::CHAN_W'($urandom_range(0, (1 << lngm_pkg::CHAN_W) - 1));
            pool_nt[i] = lngm_pkg::NOTE_W'($urandom_range(0, (1 << lngm_pkg::NOTE_W) - 1));
          end
        if (blk % 3 == 0)
          wait_all_results();
      end
      // closing stretch runs back to back
      if (done_cnt >= target - 150)
        idle_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_event(mk_event(lngm_pkg::REQ_LEARN, lngm_pkg::CHAN_W'($urandom),
                            lngm_pkg::NOTE_W'($urandom)));
        k = $urandom_range(1, lngm_pkg::SLOT_COUNT + 1);
        for (int j = 0; j < k; j++) begin
          case ($urandom_range(0, 9))
            0: begin
              pick_note(ch, nt);
              send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, ch, nt));
            end
            1: send_event(mk_event(REQ_UNUSED, lngm_pkg::CHAN_W'($urandom),
                                   lngm_pkg::NOTE_W'($urandom)));
            default: ;
          endcase
          pick_note(ch, nt);
          send_event(mk_event(lngm_pkg::REQ_NOTE_ON, ch, nt));
        end
        if (learn_on && $urandom_range(0, 1) == 1)
          send_event(mk_event(lngm_pkg::REQ_LEARN, lngm_pkg::CHAN_W'($urandom),
                              lngm_pkg::NOTE_W'($urandom)));
      end else if (r < 55) begin
        pick_slot_note(ch, nt);
        send_event(mk_event(lngm_pkg::REQ_NOTE_ON, ch, nt));
      end else if (r < 85) begin
        pick_slot_note(ch, nt);
        send_event(mk_event(lngm_pkg::REQ_NOTE_OFF, ch, nt));
      end else if (r < 95) begin
        send_event(mk_event(lngm_pkg::REQ_W'($urandom_range(0, 1)),
                            lngm_pkg::CHAN_W'($urandom), lngm_pkg::NOTE_W'($urandom)));
      end else begin
        send_event(mk_event(lngm_pkg::REQ_W'($urandom_range(0, 3)),
                            lngm_pkg::CHAN_W'($urandom), lngm_pkg::NOTE_W'($urandom)));
      end
      done_cnt = events_sent - sent0;
    end
  endtask

  // Compare each result beat with the oldest pending status
  always @(posedge clk_i) begin
    lngm_pkg::res_t exp_st;
    if (rst_ni && done_o) begin
      if (expected_status_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: actual %h", $realtime, res_o);
      end else begin
        exp_st = expected_status_q.pop_front();
        results_checked++;
        if (res_o.gate_mask !== exp_st.gate_mask) begin
          errors++;
          $display("%0t: gate_mask mismatch: expected %h actual %h",
                   $realtime, exp_st.gate_mask, res_o.gate_mask);
        end
        if (res_o.learning !== exp_st.learning) begin
          errors++;
          $display("%0t: learning mismatch: expected %h actual %h",
                   $realtime, exp_st.learning, res_o.learning);
        end
        if (res_o.learn_slot !== exp_st.learn_slot) begin
          errors++;
          $display("%0t: learn_slot mismatch: expected %h actual %h",
                   $realtime, exp_st.learn_slot, res_o.learn_slot);
        end
      end
    end
  end

  // Watchdog: too long without any beat in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("[learnable_note_gate_matcher] ERROR");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;
    test_reset_state();
    wait_all_results();
    test_learn_fill();
    test_gate_match();
    wait_all_results();
    test_relearn();
    wait_all_results();
    test_random_traffic(900);
    wait_all_results();
    if (expected_status_q.size() != 0) begin
      errors++;
      $display("%0t: %0d status beats never arrived", $realtime, expected_status_q.size());
    end
    $display("Covered %0d events (note-on %0d, note-off %0d, learn %0d, unused %0d)",
             events_sent, events_by_code[0], events_by_code[1], events_by_code[2],
             events_by_code[3]);
    $display("Checked %0d status beats, %0d mismatches", results_checked, errors);
    if (errors == 0)
      $display("[learnable_note_gate_matcher] OK");
    else
      $display("[learnable_note_gate_matcher] ERROR");
    $finish;
  end

endmodule
